### rtl/sprq_pkg.sv
// Package for the stable priority queue core.
// Holds default sizes, operation kinds and result status codes.
// No dependencies; used by every file in rtl.
`timescale 1ns / 1ps

package sprq_pkg;

  localparam int unsigned DepthDef       = 16;
  localparam int unsigned PrioBitsDef    = 8;
  localparam int unsigned PayloadBitsDef = 32;

  localparam int unsigned StatusW = 2;

  // Operation kind carried by a request.
  localparam logic KIND_INSERT = 1'b0;
  localparam logic KIND_REMOVE = 1'b1;

  // Result status codes.
  localparam logic [StatusW-1:0] STATUS_DONE  = 2'd0;
  localparam logic [StatusW-1:0] STATUS_EMPTY = 2'd1;
  localparam logic [StatusW-1:0] STATUS_FULL  = 2'd2;

endpackage

### rtl/sprq_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Depends on sprq_pkg for its default sizes; holds no reset.
`timescale 1ns / 1ps

module sprq_ram import sprq_pkg::*; #(
  parameter int unsigned Width = PrioBitsDef + PayloadBitsDef,
  parameter int unsigned Depth = DepthDef,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/stable_priority_queue_core.sv
// Top level of the stable priority queue: sorted circular list in one RAM.
// Depends on sprq_pkg and sprq_ram.
//
// Channel   Direction  Handshake                 Payload
// request   in         start && !busy            kind_i, prio_value_i, payload_tag_i
// result    out        done_o (one-cycle strobe) status_o, out_payload_o, out_prio_o,
//                                                occupancy_o
//
// A remove reads the head entry and advances the head pointer in S_POP. A result strobes
// in the cycle after the last busy one. An insert walks back from the tail: S_READ
// addresses an entry over the RAM port and S_CMP compares it, moving an entry whose
// priority is greater than the new one a slot back; S_PLACE then writes the new entry.
// An insert into a full queue or a remove from an empty one strobes without going busy.
// Reset clears the fill count and head pointer; the RAM needs no clearing.
// The receiver cannot stall; a result is valid only in its strobe cycle.
`timescale 1ns / 1ps

module stable_priority_queue_core import sprq_pkg::*; #(
  parameter int unsigned DEPTH        = DepthDef,
  parameter int unsigned PRIO_BITS    = PrioBitsDef,
  parameter int unsigned PAYLOAD_BITS = PayloadBitsDef,
  localparam int unsigned IdxW = $clog2(DEPTH),
  localparam int unsigned CntW = $clog2(DEPTH + 1)
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start,
  output logic                    busy,
  input  logic                    kind_i,
  input  logic [PRIO_BITS-1:0]    prio_value_i,
  input  logic [PAYLOAD_BITS-1:0] payload_tag_i,
  output logic                    done_o,
  output logic [StatusW-1:0]      status_o,
  output logic [PAYLOAD_BITS-1:0] out_payload_o,
  output logic [PRIO_BITS-1:0]    out_prio_o,
  output logic [CntW-1:0]         occupancy_o
);

  localparam int unsigned EntryW = PRIO_BITS + PAYLOAD_BITS;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_READ  = 3'd1;
  localparam logic [2:0] S_CMP   = 3'd2;
  localparam logic [2:0] S_PLACE = 3'd3;
  localparam logic [2:0] S_POP   = 3'd4;

  logic [2:0]              state_q, state_d;
  logic [CntW-1:0]         count_q, count_d;
  logic [IdxW-1:0]         head_q, head_d;
  logic [CntW-1:0]         pos_q, pos_d;
  logic [PRIO_BITS-1:0]    prio_q, prio_d;
  logic [PAYLOAD_BITS-1:0] tag_q, tag_d;

  logic                    done_q, done_d;
  logic [StatusW-1:0]      status_q, status_d;
  logic [PAYLOAD_BITS-1:0] opay_q, opay_d;
  logic [PRIO_BITS-1:0]    oprio_q, oprio_d;

  logic                    accept;
  logic [IdxW-1:0]         lidx;
  logic [IdxW:0]           addr_sum;
  logic [IdxW-1:0]         addr;
  logic                    we;
  logic [EntryW-1:0]       wdata;
  logic [EntryW-1:0]       rdata;
  logic [PRIO_BITS-1:0]    rd_prio;
  logic [PAYLOAD_BITS-1:0] rd_tag;
  logic [CntW-1:0]         pos_dec;

  assign accept  = start && (state_q == S_IDLE);
  assign rd_prio = rdata[EntryW-1:PAYLOAD_BITS];
  assign rd_tag  = rdata[PAYLOAD_BITS-1:0];
  assign pos_dec = pos_q - CntW'(1);

  // Logical position to physical RAM address: one shared add and wrap.
  always_comb begin
    unique case (state_q) inside
      S_READ:  lidx = pos_dec[IdxW-1:0];
      S_CMP,
      S_PLACE: lidx = pos_q[IdxW-1:0];
      default: lidx = '0;
    endcase
  end

  assign addr_sum = {1'b0, head_q} + {1'b0, lidx};
  assign addr     = (addr_sum >= (IdxW+1)'(DEPTH)) ?
                    IdxW'(addr_sum - (IdxW+1)'(DEPTH)) : addr_sum[IdxW-1:0];

  sprq_ram #(
    .Width (EntryW),
    .Depth (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (addr),
    .wdata_i (wdata),
    .raddr_i (addr),
    .rdata_o (rdata)
  );

  always_comb begin
    state_d  = state_q;
    count_d  = count_q;
    head_d   = head_q;
    pos_d    = pos_q;
    prio_d   = prio_q;
    tag_d    = tag_q;
    done_d   = 1'b0;
    status_d = status_q;
    opay_d   = opay_q;
    oprio_d  = oprio_q;
    we       = 1'b0;
    wdata    = {prio_q, tag_q};

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          prio_d = prio_value_i;
          tag_d  = payload_tag_i;
          pos_d  = count_q;
          if (kind_i == KIND_INSERT) begin
            if (count_q == CntW'(DEPTH)) begin
              done_d   = 1'b1;
              status_d = STATUS_FULL;
              opay_d   = '0;
              oprio_d  = '0;
            end else if (count_q == '0) begin
              state_d = S_PLACE;
            end else begin
              state_d = S_READ;
            end
          end else begin
            if (count_q == '0) begin
              done_d   = 1'b1;
              status_d = STATUS_EMPTY;
              opay_d   = '0;
              oprio_d  = '0;
            end else begin
              // Head entry is read at logical position zero in this cycle.
              state_d = S_POP;
            end
          end
        end
      end
      S_READ: begin
        state_d = S_CMP;
      end
      S_CMP: begin
        // Entries strictly greater move one slot back; an equal one stays ahead.
        if (rd_prio > prio_q) begin
          we    = 1'b1;
          wdata = rdata;
          pos_d = pos_dec;
          state_d = (pos_dec == '0) ? S_PLACE : S_READ;
        end else begin
          state_d = S_PLACE;
        end
      end
      S_PLACE: begin
        we       = 1'b1;
        count_d  = count_q + CntW'(1);
        done_d   = 1'b1;
        status_d = STATUS_DONE;
        opay_d   = '0;
        oprio_d  = '0;
        state_d  = S_IDLE;
      end
      S_POP: begin
        count_d  = count_q - CntW'(1);
        head_d   = (head_q == IdxW'(DEPTH - 1)) ? '0 : head_q + IdxW'(1);
        done_d   = 1'b1;
        status_d = STATUS_DONE;
        opay_d   = rd_tag;
        oprio_d  = rd_prio;
        state_d  = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
      head_q  <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      head_q  <= head_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q    <= pos_d;
    prio_q   <= prio_d;
    tag_q    <= tag_d;
    status_q <= status_d;
    opay_q   <= opay_d;
    oprio_q  <= oprio_d;
  end

  assign busy          = (state_q != S_IDLE);
  assign done_o        = done_q;
  assign status_o      = status_q;
  assign out_payload_o = opay_q;
  assign out_prio_o    = oprio_q;
  assign occupancy_o   = count_q;

`ifndef SYNTHESIS
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result strobe while the sequencer is busy");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    occupancy_o <= CntW'(DEPTH))
    else $error("occupancy above depth");

  a_full_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o == STATUS_FULL) |-> (occupancy_o == CntW'(DEPTH)))
    else $error("full status reported on a queue that is not full");

  a_empty_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o == STATUS_EMPTY) |-> (occupancy_o == '0 && out_payload_o == '0))
    else $error("empty status reported with entries or data");

  a_insert_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_PLACE) |=> (occupancy_o == $past(occupancy_o) + CntW'(1)))
    else $error("insert did not grow the queue by one");
`endif

endmodule
